@@ rtl/core/bmhq_pkg.sv @@
package bmhq_pkg;

  localparam int KEY_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 32;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] popped_value;
    logic [STATUS_W-1:0]     status;
  } out_word_t;

  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } cell_data_t;

endpackage

@@ rtl/core/bmhq_cell.sv @@
module bmhq_cell (
  input  logic                clk,
  input  logic                rst,
  input  bmhq_pkg::cell_ctrl_t ctrl,
  input  bmhq_pkg::cell_data_t prev,
  input  logic                prev_lt,
  input  bmhq_pkg::cell_data_t next,
  output bmhq_pkg::cell_data_t data,
  output logic                lt
);
  import bmhq_pkg::*;

  logic                    valid;
  logic signed [KEY_W-1:0] key;
  logic                    valid_next;
  logic signed [KEY_W-1:0] key_next;

  assign lt   = !valid || ($signed(ctrl.key) < $signed(key));
  assign data = '{valid: valid, key: key};

  always_comb begin
    valid_next = valid;
    key_next   = key;
    if (ctrl.pop) begin
      valid_next = next.valid;
      key_next   = next.key;
    end else if (ctrl.push && lt) begin
      if (prev_lt) begin
        valid_next = prev.valid;
        key_next   = prev.key;
      end else begin
        valid_next = 1'b1;
        key_next   = ctrl.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

@@ rtl/core/binary_min_heap_queue_core.sv @@
// Bounded min priority queue of signed 32-bit keys, held as a row of CAPACITY
// cells kept in ascending order: a push lets every cell compare the new key with
// its own in parallel and shift right past the insertion point, a pop shifts the
// whole row left and returns the head. One word is taken per clock cycle while
// in_ready is high, set by the row-wide compare-and-shift; its result appears
// in the output register on the next cycle. in_ready drops only while a result
// waits there unaccepted. A push into a full queue returns status 1, a pop from
// an empty one status 2, both with popped_value zero and the queue unchanged.
module binary_min_heap_queue_core #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmhq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bmhq_pkg::out_word_t out_data
);
  import bmhq_pkg::*;

  cell_ctrl_t ctrl;
  cell_data_t cell_data [CAPACITY];
  logic       cell_lt   [CAPACITY];
  logic       accept;
  logic       full;
  logic       empty;
  out_word_t  result;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign empty    = !cell_data[0].valid;
  assign full     = cell_data[CAPACITY-1].valid;

  assign ctrl.push = accept && (in_data.action == ACT_PUSH) && !full;
  assign ctrl.pop  = accept && (in_data.action == ACT_POP) && !empty;
  assign ctrl.key  = in_data.value;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_data_t prev_d;
      cell_data_t next_d;
      logic       prev_l;
      if (i == 0) begin : g_head
        assign prev_d = '0;
        assign prev_l = 1'b0;
      end else begin : g_body
        assign prev_d = cell_data[i-1];
        assign prev_l = cell_lt[i-1];
      end
      if (i == CAPACITY-1) begin : g_tail
        assign next_d = '0;
      end else begin : g_link
        assign next_d = cell_data[i+1];
      end
      bmhq_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl),
        .prev    (prev_d),
        .prev_lt (prev_l),
        .next    (next_d),
        .data    (cell_data[i]),
        .lt      (cell_lt[i])
      );
    end
  endgenerate

  always_comb begin
    result.popped_value = '0;
    result.status       = STATUS_DONE;
    if (in_data.action == ACT_PUSH) begin
      if (full) begin
        result.status = STATUS_FULL;
      end
    end else if (empty) begin
      result.status = STATUS_EMPTY;
    end else begin
      result.popped_value = cell_data[0].key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

@@ rtl/core/bmhq_checker.sv @@
module bmhq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input bmhq_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input bmhq_pkg::out_word_t out_data
);
  import bmhq_pkg::*;

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.action == ACT_PUSH |=>
      out_data.popped_value == '0 && out_data.status != STATUS_EMPTY)
    else $error("bad push result");

  a_pop_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && in_valid && in_ready && in_data.action == ACT_POP |=>
      out_data.status == STATUS_EMPTY)
    else $error("pop after reset not reported empty");

endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (.*);
